// ----- rtl/dcs_pkg.sv -----
package dcs_pkg;

  localparam int unsigned LbaW   = 32;
  localparam int unsigned CountW = 7;
  localparam int unsigned SptW   = 6;
  localparam int unsigned HpcW   = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SECTORS_PER_TRACK  = 2'd0,
    CFG_HEADS_PER_CYLINDER = 2'd1,
    CFG_DRIVE_NUMBER       = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [LbaW-1:0]   start_lba;
    logic [CountW-1:0] sector_count;
  } in_t;

  typedef struct packed {
    logic [9:0]        cylinder_index;
    logic [7:0]        head_index;
    logic [5:0]        sector_number;
    logic [CountW-1:0] chunk_sectors;
    logic [5:0]        buffer_offset;
    logic [15:0]       cx_word;
    logic [15:0]       dx_word;
    logic              cylinder_overflow;
    logic              last_chunk;
  } out_t;

endpackage

// ----- rtl/disk_read_chs_splitter_top.sv -----
// Splits a read request (start LBA, sector count) into CHS read commands, one
// output transaction per command. A chunk never crosses a cylinder boundary and
// never exceeds MAX_CHUNK_SECTORS; counts above MAX_REQUEST_SECTORS saturate and
// a zero count produces no commands. Each chunk runs through one shared
// restoring divider twice (LBA by sectors per track, then track by heads per
// cylinder, one quotient bit per cycle), followed by a multiply step. The
// input is stalled while a request is being split; the last command sits in the
// output register while the next request is accepted. A zero geometry register
// is treated as one. The user must write configuration only while the block is
// idle; the block itself does not enforce this.
module disk_read_chs_splitter_top
  import dcs_pkg::*;
#(
  parameter int unsigned MAX_CHUNK_SECTORS   = 127,
  parameter int unsigned MAX_REQUEST_SECTORS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_t                 in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_t                out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam logic [CountW-1:0] MaxChunk   = CountW'(MAX_CHUNK_SECTORS);
  localparam logic [CountW-1:0] MaxRequest = CountW'(MAX_REQUEST_SECTORS);
  localparam int unsigned       BitCntW    = $clog2(LbaW);
  localparam logic [BitCntW-1:0] LastBit   = BitCntW'(LbaW - 1);
  localparam int unsigned       ProdW      = SptW + HpcW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_SPT,
    ST_DIV_HPC,
    ST_MUL,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  logic [SptW-1:0]     spt_r;
  logic [HpcW-1:0]     hpc_r;
  logic [7:0]          drive_r;

  logic [LbaW-1:0]     lba_r;
  logic [CountW-1:0]   left_r;
  logic [CountW-1:0]   done_r;

  logic [LbaW-1:0]     div_q_r;
  logic [HpcW-1:0]     div_rem_r;
  logic [BitCntW-1:0]  bit_cnt_r;
  logic [SptW-1:0]     rem1_r;
  logic [HpcW-1:0]     head_r;
  logic [ProdW-1:0]    cap_r;
  logic [ProdW-1:0]    used_r;

  out_t                out_r;
  logic                out_valid_r;

  logic [SptW-1:0]     spt_eff;
  logic [HpcW-1:0]     hpc_eff;
  logic [HpcW-1:0]     divisor;
  logic [HpcW:0]       rem_sh;
  logic                q_bit;
  logic [HpcW-1:0]     rem_new;
  logic [LbaW-1:0]     q_new;

  logic                in_fire;
  logic [CountW-1:0]   req_count;
  logic                emit_fire;
  logic [ProdW-1:0]    room;
  logic [CountW-1:0]   take_cap;
  logic [CountW-1:0]   take;
  logic [CountW-1:0]   left_after;
  logic [9:0]          c10;
  logic [5:0]          sect;

  assign spt_eff = (spt_r == '0) ? SptW'(1) : spt_r;
  assign hpc_eff = (hpc_r == '0) ? HpcW'(1) : hpc_r;
  assign divisor = (state_r == ST_DIV_SPT) ? HpcW'(spt_eff) : hpc_eff;

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh  = {div_rem_r, div_q_r[LbaW-1]};
  assign q_bit   = (rem_sh >= {1'b0, divisor});
  assign rem_new = q_bit ? HpcW'(rem_sh - {1'b0, divisor}) : rem_sh[HpcW-1:0];
  assign q_new   = {div_q_r[LbaW-2:0], q_bit};

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign req_count = (in_data.sector_count > MaxRequest) ? MaxRequest : in_data.sector_count;

  assign emit_fire  = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign room       = cap_r - used_r;
  assign take_cap   = (room > ProdW'(MaxChunk)) ? MaxChunk : room[CountW-1:0];
  assign take       = (left_r < take_cap) ? left_r : take_cap;
  assign left_after = left_r - take;
  assign c10        = div_q_r[9:0];
  assign sect       = rem1_r + SptW'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && req_count != '0) state_nxt = ST_DIV_SPT;
      end
      ST_DIV_SPT: begin
        if (bit_cnt_r == LastBit) state_nxt = ST_DIV_HPC;
      end
      ST_DIV_HPC: begin
        if (bit_cnt_r == LastBit) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_fire) state_nxt = (left_after == '0) ? ST_IDLE : ST_DIV_SPT;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      spt_r       <= SptW'(63);
      hpc_r       <= HpcW'(16);
      drive_r     <= 8'd128;
      lba_r       <= '0;
      left_r      <= '0;
      done_r      <= '0;
      bit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SECTORS_PER_TRACK:  spt_r   <= cfg_data[SptW-1:0];
          CFG_HEADS_PER_CYLINDER: hpc_r   <= cfg_data[HpcW-1:0];
          CFG_DRIVE_NUMBER:       drive_r <= cfg_data;
          default: ;
        endcase
      end

      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            lba_r     <= in_data.start_lba;
            left_r    <= req_count;
            done_r    <= '0;
            div_q_r   <= in_data.start_lba;
            div_rem_r <= '0;
            bit_cnt_r <= '0;
          end
        end
        ST_DIV_SPT: begin
          bit_cnt_r <= bit_cnt_r + BitCntW'(1);
          div_q_r   <= q_new;
          if (bit_cnt_r == LastBit) begin
            // Quotient is the track; restart the divider on it with a clear remainder.
            rem1_r    <= rem_new[SptW-1:0];
            div_rem_r <= '0;
          end else begin
            div_rem_r <= rem_new;
          end
        end
        ST_DIV_HPC: begin
          bit_cnt_r <= bit_cnt_r + BitCntW'(1);
          div_q_r   <= q_new;
          div_rem_r <= rem_new;
          if (bit_cnt_r == LastBit) head_r <= rem_new;
        end
        ST_MUL: begin
          cap_r  <= ProdW'(hpc_eff) * ProdW'(spt_eff);
          used_r <= ProdW'(head_r) * ProdW'(spt_eff) + ProdW'(rem1_r);
        end
        ST_EMIT: begin
          if (emit_fire) begin
            out_r.cylinder_index    <= c10;
            out_r.head_index        <= head_r;
            out_r.sector_number     <= sect;
            out_r.chunk_sectors     <= take;
            out_r.buffer_offset     <= done_r[5:0];
            out_r.cx_word           <= {c10[7:0], c10[9:8], sect};
            out_r.dx_word           <= {head_r, drive_r};
            out_r.cylinder_overflow <= |div_q_r[LbaW-1:10];
            out_r.last_chunk        <= (left_after == '0);
            left_r    <= left_after;
            done_r    <= done_r + take;
            lba_r     <= lba_r + LbaW'(take);
            div_q_r   <= lba_r + LbaW'(take);
            div_rem_r <= '0;
            bit_cnt_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("output became valid outside the emit state");

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (left_r == '0))
    else $error("idle with sectors still left in the request");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_SPT || state_r == ST_DIV_HPC) |-> (div_rem_r < divisor))
    else $error("divider remainder not below divisor");

  a_take_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.chunk_sectors != '0))
    else $error("command issued with zero sectors");

endmodule
